// ===== hdl/ctp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_pkg: shared definitions for the column token type profiler
// Sizes, character codes, recognizer state types and small helper functions.
// ----------------------------------------------------------------------------
package ctp_pkg;

  // sizes
  localparam int MAX_COLUMNS  = 64;
  localparam int COUNTER_BITS = 32;
  localparam int COL_W        = $clog2(MAX_COLUMNS + 1);
  localparam int ADDR_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W        = COUNTER_BITS;
  localparam int OUT_CNT_W    = 32;
  localparam int OUT_COL_W    = 7;

  // character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_LE    = 8'h65;

  // item kinds carried on tuser
  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // integer form recognizer
  typedef enum logic [1:0] {
    IR_START,
    IR_DIGITS,
    IR_DEAD
  } ir_state_t;

  // float form recognizer
  typedef enum logic [2:0] {
    FR_START,
    FR_MANT,
    FR_FRAC,
    FR_EXPMARK,
    FR_EXP,
    FR_DEAD
  } fr_state_t;

  // class flags of one finished token
  typedef struct packed {
    logic alnum;
    logic alpha;
    logic integ;
    logic flt;
    logic other;
  } tok_class_t;

  // one memory word: all counters of one column
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] alnum;
    logic [CNT_W-1:0] alpha;
    logic [CNT_W-1:0] integ;
    logic [CNT_W-1:0] flt;
    logic [CNT_W-1:0] other;
  } col_counts_t;

  // saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic en);
    if (en && (c != {CNT_W{1'b1}})) begin
      return c + CNT_W'(1);
    end
    return c;
  endfunction

  // low 32 bits of a counter
  function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] t;
    t = {{OUT_CNT_W{1'b0}}, c};
    return t[OUT_CNT_W-1:0];
  endfunction

  // column count shown saturated at 127
  function automatic logic [OUT_COL_W-1:0] cap7(input logic [COL_W-1:0] v);
    logic [COL_W+OUT_COL_W-1:0] t;
    t = {{OUT_COL_W{1'b0}}, v};
    if (t > (COL_W + OUT_COL_W)'(127)) begin
      return OUT_COL_W'(127);
    end
    return t[OUT_COL_W-1:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return c inside {CH_PLUS, CH_MINUS};
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return c inside {CH_UE, CH_LE};
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};
  endfunction

endpackage

// ===== hdl/column_token_type_profiler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_token_type_profiler: per-column token class statistics of a text
// Classifies whitespace separated tokens and counts classes per column.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one word per item. in_tuser is the item
// kind: text byte or read of one column's counters. A text byte of newline
// ends a line; space, tab, CR, VT and FF separate tokens. Every accepted
// item returns exactly one result word; a newline result has tlast set and
// reports the line's column count, an empty-line flag and a mismatch flag
// against the previous line. A read returns the six counters of a column.
// The accepting edge reads the counter memory into the memory stage; when
// that stage moves on, the update is applied, written back and loaded
// into the output register, which drives out_tvalid. One word per cycle
// is sustained while out_tready stays high; a commit of the column
// counters that meets a read of the same entry is forwarded.
// Reset clears the per-entry valid bits, so all counters read as zero at
// once; no clearing pass is needed. When the receiver holds out_tready low
// the output register and the memory stage hold, and in_tready drops once
// both are full.
// ----------------------------------------------------------------------------
module column_token_type_profiler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] char_code, [13:8] column, [15:14] zero
  input  logic [15:0]  in_tdata,
  // [0] func
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] column_mismatch, [1] line_empty, [33:2] line_number,
  // [40:34] columns_in_line, [72:41] total_count, [104:73] alnum_count,
  // [136:105] alpha_count, [168:137] integer_count, [200:169] float_count,
  // [232:201] other_count, [239:233] widest_line_columns
  output logic [239:0] out_tdata,
  // line_end
  output logic         out_tlast
);

  localparam int ADDR_W = ctp_pkg::ADDR_W;
  localparam int COL_W  = ctp_pkg::COL_W;

  // input fields
  logic       in_func;
  logic [7:0] in_char;
  logic [5:0] in_col;
  logic       in_acc;

  assign in_func = in_tuser[0];
  assign in_char = in_tdata[7:0];
  assign in_col  = in_tdata[13:8];
  assign in_acc  = in_tvalid && in_tready;

  // counter memory and its entry valid bits
  ctp_pkg::col_counts_t cnt_mem [ctp_pkg::MAX_COLUMNS];
  logic [ctp_pkg::MAX_COLUMNS-1:0] ent_vld_r;
  ctp_pkg::col_counts_t mem_q_r;

  // line and token state
  logic [31:0]           lines_r, lines_nxt;
  logic [COL_W-1:0]      cur_col_r, cur_col_nxt;
  logic [COL_W-1:0]      prev_cols_r, prev_cols_nxt;
  logic [COL_W-1:0]      widest_r, widest_nxt;
  logic                  in_tok_r, in_tok_nxt;
  logic                  alnum_ok_r, alnum_ok_nxt;
  logic                  alpha_ok_r, alpha_ok_nxt;
  ctp_pkg::ir_state_t    ir_r, ir_nxt, ir_feed;
  ctp_pkg::fr_state_t    fr_r, fr_nxt, fr_feed;

  // memory stage registers
  logic                  s1_v_r;
  logic                  s1_func_r;
  logic                  s1_commit_r;
  logic                  s1_inrange_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  ctp_pkg::tok_class_t   s1_cls_r;
  logic                  s1_line_end_r;
  logic                  s1_mismatch_r;
  logic                  s1_empty_r;
  logic [6:0]            s1_cols_r;
  logic [31:0]           s1_lines_r;
  logic [6:0]            s1_widest_r;
  logic                  s1_ent_vld_r;
  logic                  fwd_hit_r;
  ctp_pkg::col_counts_t  fwd_data_r;

  // output register
  logic                  out_v_r;
  logic [239:0]          out_data_r;
  logic                  out_last_r;

  // stage handshake
  logic s1_go;
  assign s1_go     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;

  // character classes of the incoming byte
  logic ch_d, ch_l, ch_s, ch_e, ch_nl, ch_sep;
  assign ch_d   = ctp_pkg::is_digit(in_char);
  assign ch_l   = ctp_pkg::is_letter(in_char);
  assign ch_s   = ctp_pkg::is_sign(in_char);
  assign ch_e   = ctp_pkg::is_exp(in_char);
  assign ch_nl  = (in_char == ctp_pkg::CH_NL);
  assign ch_sep = ctp_pkg::is_sep(in_char);

  // integer recognizer next state on a fed byte
  always_comb begin
    case (ir_r)
      ctp_pkg::IR_START:  ir_feed = (ch_d || ch_s) ? ctp_pkg::IR_DIGITS : ctp_pkg::IR_DEAD;
      ctp_pkg::IR_DIGITS: ir_feed = ch_d ? ctp_pkg::IR_DIGITS : ctp_pkg::IR_DEAD;
      default:            ir_feed = ctp_pkg::IR_DEAD;
    endcase
  end

  // float recognizer next state on a fed byte
  always_comb begin
    case (fr_r)
      ctp_pkg::FR_START, ctp_pkg::FR_MANT: begin
        if (ch_d || (ch_s && (fr_r == ctp_pkg::FR_START))) begin
          fr_feed = ctp_pkg::FR_MANT;
        end else if (in_char == ctp_pkg::CH_DOT) begin
          fr_feed = ctp_pkg::FR_FRAC;
        end else if (ch_e) begin
          fr_feed = ctp_pkg::FR_EXPMARK;
        end else begin
          fr_feed = ctp_pkg::FR_DEAD;
        end
      end
      ctp_pkg::FR_FRAC: begin
        if (ch_d) begin
          fr_feed = ctp_pkg::FR_FRAC;
        end else if (ch_e) begin
          fr_feed = ctp_pkg::FR_EXPMARK;
        end else begin
          fr_feed = ctp_pkg::FR_DEAD;
        end
      end
      ctp_pkg::FR_EXPMARK: fr_feed = (ch_d || ch_s) ? ctp_pkg::FR_EXP : ctp_pkg::FR_DEAD;
      ctp_pkg::FR_EXP:     fr_feed = ch_d ? ctp_pkg::FR_EXP : ctp_pkg::FR_DEAD;
      default:             fr_feed = ctp_pkg::FR_DEAD;
    endcase
  end

  // recognizer outputs: class of the token held so far
  ctp_pkg::tok_class_t tok_cls;
  always_comb begin
    tok_cls.alnum = alnum_ok_r;
    tok_cls.alpha = alnum_ok_r && alpha_ok_r;
    tok_cls.flt   = (fr_r != ctp_pkg::FR_DEAD);
    tok_cls.integ = (fr_r != ctp_pkg::FR_DEAD) && (ir_r != ctp_pkg::IR_DEAD);
    tok_cls.other = !alnum_ok_r && (fr_r == ctp_pkg::FR_DEAD);
  end

  // token end decision
  logic             is_text, tok_end, commit;
  logic [COL_W-1:0] col_after;
  assign is_text   = (in_func == ctp_pkg::FUNC_TEXT);
  assign tok_end   = is_text && (ch_nl || ch_sep);
  assign commit    = tok_end && in_tok_r && (cur_col_r < COL_W'(ctp_pkg::MAX_COLUMNS));
  assign col_after = commit ? cur_col_r + COL_W'(1) : cur_col_r;

  // line and token state next values
  logic mismatch, empty_line;
  always_comb begin
    lines_nxt     = lines_r;
    cur_col_nxt   = cur_col_r;
    prev_cols_nxt = prev_cols_r;
    widest_nxt    = widest_r;
    in_tok_nxt    = in_tok_r;
    alnum_ok_nxt  = alnum_ok_r;
    alpha_ok_nxt  = alpha_ok_r;
    ir_nxt        = ir_r;
    fr_nxt        = fr_r;
    mismatch      = 1'b0;
    empty_line    = 1'b0;
    if (is_text) begin
      if (tok_end) begin
        in_tok_nxt   = 1'b0;
        alnum_ok_nxt = 1'b1;
        alpha_ok_nxt = 1'b1;
        ir_nxt       = ctp_pkg::IR_START;
        fr_nxt       = ctp_pkg::FR_START;
        cur_col_nxt  = col_after;
      end else begin
        in_tok_nxt   = 1'b1;
        alnum_ok_nxt = alnum_ok_r && (ch_d || ch_l);
        alpha_ok_nxt = alpha_ok_r && ch_l;
        ir_nxt       = ir_feed;
        fr_nxt       = fr_feed;
      end
      if (ch_nl) begin
        if (lines_r != 32'hFFFF_FFFF) begin
          lines_nxt = lines_r + 32'd1;
        end
        if (col_after > widest_r) begin
          widest_nxt = col_after;
        end
        mismatch      = (col_after != prev_cols_r) && (lines_nxt != 32'd1);
        empty_line    = (col_after == '0);
        prev_cols_nxt = col_after;
        cur_col_nxt   = '0;
      end
    end
  end

  // read address: column of a read item, current column of a commit
  logic [ADDR_W+5:0] rd_col_ext;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_inrange;
  assign rd_col_ext = {{ADDR_W{1'b0}}, in_col};
  assign rd_inrange = (rd_col_ext < (ADDR_W + 6)'(ctp_pkg::MAX_COLUMNS));
  assign rd_addr    = is_text ? cur_col_r[ADDR_W-1:0] : rd_col_ext[ADDR_W-1:0];

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r     <= '0;
      cur_col_r   <= '0;
      prev_cols_r <= '0;
      widest_r    <= '0;
      in_tok_r    <= 1'b0;
      alnum_ok_r  <= 1'b1;
      alpha_ok_r  <= 1'b1;
      ir_r        <= ctp_pkg::IR_START;
      fr_r        <= ctp_pkg::FR_START;
    end else if (in_acc) begin
      lines_r     <= lines_nxt;
      cur_col_r   <= cur_col_nxt;
      prev_cols_r <= prev_cols_nxt;
      widest_r    <= widest_nxt;
      in_tok_r    <= in_tok_nxt;
      alnum_ok_r  <= alnum_ok_nxt;
      alpha_ok_r  <= alpha_ok_nxt;
      ir_r        <= ir_nxt;
      fr_r        <= fr_nxt;
    end
  end

  // memory stage update
  ctp_pkg::col_counts_t cur_cnt, upd_cnt;
  logic                 wr_en;
  always_comb begin
    if (fwd_hit_r) begin
      cur_cnt = fwd_data_r;
    end else if (s1_ent_vld_r) begin
      cur_cnt = mem_q_r;
    end else begin
      cur_cnt = '0;
    end
    upd_cnt.total = ctp_pkg::sat_inc(cur_cnt.total, 1'b1);
    upd_cnt.alnum = ctp_pkg::sat_inc(cur_cnt.alnum, s1_cls_r.alnum);
    upd_cnt.alpha = ctp_pkg::sat_inc(cur_cnt.alpha, s1_cls_r.alpha);
    upd_cnt.integ = ctp_pkg::sat_inc(cur_cnt.integ, s1_cls_r.integ);
    upd_cnt.flt   = ctp_pkg::sat_inc(cur_cnt.flt, s1_cls_r.flt);
    upd_cnt.other = ctp_pkg::sat_inc(cur_cnt.other, s1_cls_r.other);
  end
  assign wr_en = s1_go && s1_commit_r;

  // counter memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[s1_addr_r] <= upd_cnt;
    end
    if (in_acc) begin
      mem_q_r <= cnt_mem[rd_addr];
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (wr_en) begin
      ent_vld_r[s1_addr_r] <= 1'b1;
    end
  end

  // memory stage pipeline register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r     <= in_func;
      s1_commit_r   <= commit;
      s1_inrange_r  <= rd_inrange;
      s1_addr_r     <= rd_addr;
      s1_cls_r      <= tok_cls;
      s1_line_end_r <= is_text && ch_nl;
      s1_mismatch_r <= mismatch;
      s1_empty_r    <= empty_line;
      s1_cols_r     <= (is_text && ch_nl) ? ctp_pkg::cap7(col_after) : 7'd0;
      s1_lines_r    <= lines_nxt;
      s1_widest_r   <= ctp_pkg::cap7(widest_nxt);
      s1_ent_vld_r  <= ent_vld_r[rd_addr];
      // write back in the same cycle as this read
      fwd_hit_r     <= wr_en && (s1_addr_r == rd_addr);
      fwd_data_r    <= upd_cnt;
    end
  end

  // result word
  ctp_pkg::col_counts_t rd_cnt;
  logic [239:0]         res_data;
  always_comb begin
    rd_cnt = (s1_func_r == ctp_pkg::FUNC_READ && s1_inrange_r) ? cur_cnt : '0;
    res_data = {
      s1_widest_r,
      ctp_pkg::cnt_out(rd_cnt.other),
      ctp_pkg::cnt_out(rd_cnt.flt),
      ctp_pkg::cnt_out(rd_cnt.integ),
      ctp_pkg::cnt_out(rd_cnt.alpha),
      ctp_pkg::cnt_out(rd_cnt.alnum),
      ctp_pkg::cnt_out(rd_cnt.total),
      s1_cols_r,
      s1_lines_r,
      s1_empty_r,
      s1_mismatch_r
    };
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= res_data;
      out_last_r <= s1_line_end_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // the column count never runs past the limit
  a_col_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cur_col_r <= COL_W'(ctp_pkg::MAX_COLUMNS))
    else $error("current column beyond limit");

  // a mismatch or empty flag only comes with a line end
  a_flags_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] || out_tdata[1]) |-> out_tlast)
    else $error("line flag without line end");

  // an empty line reports zero columns
  a_empty_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> (out_tdata[40:34] == 7'd0))
    else $error("empty line with columns");

  // a read item never writes the counter memory
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_func_r == ctp_pkg::FUNC_TEXT) && s1_v_r)
    else $error("counter write from a read item");

  // a set forward flag holds while the memory stage is empty
  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r && !s1_v_r |-> $stable(fwd_hit_r))
    else $error("forward flag changed with empty stage");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the column token type profiler
// Streams text bytes and column reads into the block with random gaps on both
// sides, predicts every result word from its own copy of the token and column
// state, and checks each result field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;

  // result word as laid out on out_tdata, msb first
  typedef struct packed {
    logic [6:0]  widest;
    logic [31:0] other;
    logic [31:0] flt;
    logic [31:0] integ;
    logic [31:0] alpha;
    logic [31:0] alnum;
    logic [31:0] total;
    logic [6:0]  cols;
    logic [31:0] line_no;
    logic        empty;
    logic        mism;
  } stats_word_t;

  typedef struct {
    logic        last;
    stats_word_t w;
  } line_stats_t;

  // predicted column statistics and the queue of results still due
  class token_profile_board;
    logic [31:0] tot_cnt[ctp_pkg::MAX_COLUMNS];
    logic [31:0] aln_cnt[ctp_pkg::MAX_COLUMNS];
    logic [31:0] alp_cnt[ctp_pkg::MAX_COLUMNS];
    logic [31:0] int_cnt[ctp_pkg::MAX_COLUMNS];
    logic [31:0] flt_cnt[ctp_pkg::MAX_COLUMNS];
    logic [31:0] oth_cnt[ctp_pkg::MAX_COLUMNS];
    logic [31:0] lines;
    logic [6:0]  cur_col;
    logic [6:0]  prev_cols;
    logic [6:0]  widest;
    logic        in_tok;
    logic        aln_ok;
    logic        alp_ok;
    ctp_pkg::ir_state_t int_st;
    ctp_pkg::fr_state_t flt_st;
    line_stats_t expected_stats[$];
    int          errors;

    function new();
      foreach (tot_cnt[i]) begin
        tot_cnt[i] = '0;
        aln_cnt[i] = '0;
        alp_cnt[i] = '0;
        int_cnt[i] = '0;
        flt_cnt[i] = '0;
        oth_cnt[i] = '0;
      end
      lines     = '0;
      cur_col   = '0;
      prev_cols = '0;
      widest    = '0;
      errors    = 0;
      clear_token();
    endfunction

    static function logic is_gap(logic [7:0] c);
      return c inside {ctp_pkg::CH_SP, ctp_pkg::CH_TAB, ctp_pkg::CH_CR,
                       ctp_pkg::CH_VT, ctp_pkg::CH_FF};
    endfunction

    static function logic is_numeral(logic [7:0] c);
      return c inside {["0":"9"]};
    endfunction

    static function logic is_latin(logic [7:0] c);
      return c inside {["A":"Z"], ["a":"z"]};
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function void clear_token();
      in_tok = 1'b0;
      aln_ok = 1'b1;
      alp_ok = 1'b1;
      int_st = ctp_pkg::IR_START;
      flt_st = ctp_pkg::FR_START;
    endfunction

    // advance the class recognizers by one token byte
    function void feed(logic [7:0] c);
      logic d, sg, ex;
      d  = is_numeral(c);
      sg = c inside {ctp_pkg::CH_PLUS, ctp_pkg::CH_MINUS};
      ex = c inside {ctp_pkg::CH_UE, ctp_pkg::CH_LE};
      in_tok = 1'b1;
      if (!(d || is_latin(c))) aln_ok = 1'b0;
      if (!is_latin(c)) alp_ok = 1'b0;
      case (int_st)
        ctp_pkg::IR_START:  int_st = (d || sg) ? ctp_pkg::IR_DIGITS : ctp_pkg::IR_DEAD;
        ctp_pkg::IR_DIGITS: int_st = d ? ctp_pkg::IR_DIGITS : ctp_pkg::IR_DEAD;
        default:            int_st = ctp_pkg::IR_DEAD;
      endcase
      case (flt_st)
        ctp_pkg::FR_START: begin
          if (d || sg) flt_st = ctp_pkg::FR_MANT;
          else if (c == ctp_pkg::CH_DOT) flt_st = ctp_pkg::FR_FRAC;
          else if (ex) flt_st = ctp_pkg::FR_EXPMARK;
          else flt_st = ctp_pkg::FR_DEAD;
        end
        ctp_pkg::FR_MANT: begin
          if (d) flt_st = ctp_pkg::FR_MANT;
          else if (c == ctp_pkg::CH_DOT) flt_st = ctp_pkg::FR_FRAC;
          else if (ex) flt_st = ctp_pkg::FR_EXPMARK;
          else flt_st = ctp_pkg::FR_DEAD;
        end
        ctp_pkg::FR_FRAC: begin
          if (d) flt_st = ctp_pkg::FR_FRAC;
          else if (ex) flt_st = ctp_pkg::FR_EXPMARK;
          else flt_st = ctp_pkg::FR_DEAD;
        end
        ctp_pkg::FR_EXPMARK: flt_st = (d || sg) ? ctp_pkg::FR_EXP : ctp_pkg::FR_DEAD;
        ctp_pkg::FR_EXP:     flt_st = d ? ctp_pkg::FR_EXP : ctp_pkg::FR_DEAD;
        default:             flt_st = ctp_pkg::FR_DEAD;
      endcase
    endfunction

    // close the current token into its column counters
    function void commit();
      logic       fl;
      logic [5:0] k;
      if (in_tok && cur_col < ctp_pkg::MAX_COLUMNS) begin
        k  = cur_col[5:0];
        fl = flt_st != ctp_pkg::FR_DEAD;
        tot_cnt[k] = bump(tot_cnt[k]);
        if (aln_ok) begin
          aln_cnt[k] = bump(aln_cnt[k]);
          if (alp_ok) alp_cnt[k] = bump(alp_cnt[k]);
        end
        if (fl) begin
          flt_cnt[k] = bump(flt_cnt[k]);
          if (int_st != ctp_pkg::IR_DEAD) int_cnt[k] = bump(int_cnt[k]);
        end
        if (!aln_ok && !fl) oth_cnt[k] = bump(oth_cnt[k]);
        cur_col++;
      end
      clear_token();
    endfunction

    // accepted input word: work out its result
    function void note_word(logic f, logic [7:0] ch, logic [5:0] col);
      line_stats_t e;
      logic [6:0]  n;
      e.last = 1'b0;
      e.w    = '0;
      if (f == ctp_pkg::FUNC_READ) begin
        e.w.total = tot_cnt[col];
        e.w.alnum = aln_cnt[col];
        e.w.alpha = alp_cnt[col];
        e.w.integ = int_cnt[col];
        e.w.flt   = flt_cnt[col];
        e.w.other = oth_cnt[col];
      end else if (ch == ctp_pkg::CH_NL) begin
        commit();
        n = cur_col;
        if (lines != '1) lines++;
        if (n > widest) widest = n;
        e.last    = 1'b1;
        e.w.mism  = (n != prev_cols) && (lines != 32'd1);
        e.w.empty = n == 7'd0;
        e.w.cols  = n;
        prev_cols = n;
        cur_col   = '0;
      end else if (is_gap(ch)) begin
        commit();
      end else begin
        feed(ch);
      end
      e.w.line_no = lines;
      e.w.widest  = widest;
      expected_stats.push_back(e);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    // accepted result word: compare with the oldest prediction
    function void check_word(logic [239:0] data, logic last);
      stats_word_t a;
      line_stats_t e;
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %0h", $time, data);
        return;
      end
      e = expected_stats.pop_front();
      a = data;
      cmp("line_end", 32'(e.last), 32'(last));
      cmp("column_mismatch", 32'(e.w.mism), 32'(a.mism));
      cmp("line_empty", 32'(e.w.empty), 32'(a.empty));
      cmp("line_number", e.w.line_no, a.line_no);
      cmp("columns_in_line", 32'(e.w.cols), 32'(a.cols));
      cmp("total_count", e.w.total, a.total);
      cmp("alnum_count", e.w.alnum, a.alnum);
      cmp("alpha_count", e.w.alpha, a.alpha);
      cmp("integer_count", e.w.integ, a.integ);
      cmp("float_count", e.w.flt, a.flt);
      cmp("other_count", e.w.other, a.other);
      cmp("widest_line_columns", 32'(e.w.widest), 32'(a.widest));
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [239:0] out_tdata;
  logic         out_tlast;

  token_profile_board sb;
  int                 n_sent;
  int                 n_seen;
  logic [7:0]         tok_bytes[$];

  column_token_type_profiler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("[column_token_type_profiler] ERROR");
    $finish;
  end

  // one input word; valid stays high across back-to-back words
  task automatic send_item(input logic f, input logic [7:0] ch, input logic [5:0] col);
    int   gap;
    logic ok;
    if (((n_sent / 64) % 4) == 1) gap = 0;
    else gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {2'b00, col, ch};
    forever begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
      if (ok) break;
    end
    sb.note_word(f, ch, col);
    n_sent++;
  endtask

  task automatic send_text(input logic [7:0] ch);
    send_item(ctp_pkg::FUNC_TEXT, ch, 6'($urandom_range(0, 63)));
  endtask

  // reads favor the low columns, where most tokens land
  task automatic send_read();
    logic [5:0] col;
    if ($urandom_range(0, 1) == 0) col = 6'($urandom_range(0, 7));
    else col = 6'($urandom_range(0, 63));
    send_item(ctp_pkg::FUNC_READ, 8'($urandom_range(0, 255)), col);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_stats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(0, 1) ? ctp_pkg::CH_PLUS : ctp_pkg::CH_MINUS;
  endfunction

  function automatic logic [7:0] rand_glyph();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ctp_pkg::CH_NL || token_profile_board::is_gap(b));
    return b;
  endfunction

  function automatic logic [7:0] rand_sep();
    case ($urandom_range(0, 4))
      0:       return ctp_pkg::CH_SP;
      1:       return ctp_pkg::CH_TAB;
      2:       return ctp_pkg::CH_CR;
      3:       return ctp_pkg::CH_VT;
      default: return ctp_pkg::CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] rand_special();
    case ($urandom_range(0, 4))
      0:       return ctp_pkg::CH_DOT;
      1:       return ctp_pkg::CH_LE;
      2:       return ctp_pkg::CH_UE;
      3:       return ctp_pkg::CH_PLUS;
      default: return ctp_pkg::CH_MINUS;
    endcase
  endfunction

  // one random token into tok_bytes
  function automatic void build_token();
    int kind;
    tok_bytes.delete();
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        if ($urandom_range(0, 2) == 0) tok_bytes.push_back(rand_sign());
        repeat ($urandom_range(1, 4)) tok_bytes.push_back(rand_digit());
      end
      2, 3, 9: begin
        if ($urandom_range(0, 2) == 0) tok_bytes.push_back(rand_sign());
        repeat ($urandom_range(0, 3)) tok_bytes.push_back(rand_digit());
        if ($urandom_range(0, 1)) tok_bytes.push_back(ctp_pkg::CH_DOT);
        repeat ($urandom_range(0, 3)) tok_bytes.push_back(rand_digit());
        if ($urandom_range(0, 1)) begin
          tok_bytes.push_back($urandom_range(0, 1) ? ctp_pkg::CH_LE : ctp_pkg::CH_UE);
          if ($urandom_range(0, 1)) tok_bytes.push_back(rand_sign());
          repeat ($urandom_range(0, 2)) tok_bytes.push_back(rand_digit());
        end
        if (tok_bytes.size() == 0) tok_bytes.push_back(rand_digit());
        // broken float: one stray byte at the end
        if (kind == 9) begin
          case ($urandom_range(0, 2))
            0:       tok_bytes.push_back(rand_special());
            1:       tok_bytes.push_back(rand_letter());
            default: tok_bytes.push_back(rand_glyph());
          endcase
        end
      end
      4: repeat ($urandom_range(1, 5)) tok_bytes.push_back(rand_letter());
      5: repeat ($urandom_range(1, 6))
        tok_bytes.push_back($urandom_range(0, 1) ? rand_letter() : rand_digit());
      6: tok_bytes.push_back(rand_special());
      7: repeat ($urandom_range(1, 3)) tok_bytes.push_back(rand_glyph());
      default: begin
        repeat ($urandom_range(1, 3)) tok_bytes.push_back(rand_letter());
        tok_bytes.push_back(rand_glyph());
      end
    endcase
  endfunction

  // one text line of ntok tokens with random separators
  task automatic emit_line(input int ntok);
    logic [7:0] word_q[$];
    if ($urandom_range(0, 3) == 0) send_text(rand_sep());
    for (int t = 0; t < ntok; t++) begin
      build_token();
      word_q = tok_bytes;
      foreach (word_q[i]) send_text(word_q[i]);
      if (t < ntok - 1 || $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 2)) send_text(rand_sep());
      if ($urandom_range(0, 15) == 0) send_read();
    end
    send_text(ctp_pkg::CH_NL);
  endtask

  // result side: random stalls, one long hold, stretches with none
  initial begin
    int   gap;
    logic ok;
    logic [239:0] data;
    logic last;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (n_seen == 400) gap = 90;
      else if (((n_seen / 64) % 4) == 2) gap = 0;
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      forever begin
        @(negedge clk);
        ok   = out_tvalid;
        data = out_tdata;
        last = out_tlast;
        @(posedge clk);
        if (ok) break;
      end
      sb.check_word(data, last);
      n_seen++;
    end
  end

  // stimulus and end of run
  initial begin
    logic [7:0] line_two[$];
    logic [7:0] line_three[$];
    int         pick;
    bit         paused;
    sb         = new();
    n_sent     = 0;
    n_seen     = 0;
    paused     = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ctp_pkg::FUNC_TEXT;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty first line, lone specials and odd bytes, then a line of two
    line_two = '{ctp_pkg::CH_PLUS, ctp_pkg::CH_SP, ctp_pkg::CH_DOT, ctp_pkg::CH_TAB,
                 ctp_pkg::CH_UE, ctp_pkg::CH_CR, "1", ctp_pkg::CH_LE, ctp_pkg::CH_PLUS,
                 ctp_pkg::CH_VT, 8'h00, ctp_pkg::CH_FF, 8'hFF, ctp_pkg::CH_NL};
    line_three = '{"A", "z", ctp_pkg::CH_SP, ctp_pkg::CH_MINUS, "5", ctp_pkg::CH_DOT,
                   ctp_pkg::CH_LE, "7", ctp_pkg::CH_NL};
    send_item(ctp_pkg::FUNC_READ, 8'h00, 6'd63);
    send_text(ctp_pkg::CH_NL);
    foreach (line_two[i]) send_text(line_two[i]);
    foreach (line_three[i]) send_text(line_three[i]);
    send_item(ctp_pkg::FUNC_READ, 8'hFF, 6'd0);
    wait_drained();

    // random lines, reads and noise bytes
    while (n_sent < 1430) begin
      if (!paused && n_sent > 700) begin
        wait_drained();
        paused = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) send_read();
      else if (pick < 16) send_text(8'($urandom_range(0, 255)));
      else if (pick < 19) emit_line($urandom_range(60, 70));
      else emit_line($urandom_range(0, 6));
    end
    // final reads of the first and last columns
    send_item(ctp_pkg::FUNC_READ, 8'h00, 6'd0);
    send_item(ctp_pkg::FUNC_READ, 8'h00, 6'd63);
    in_tvalid <= 1'b0;

    for (int w = 0; w < 20000 && sb.expected_stats.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.expected_stats.size() != 0) begin
      sb.errors++;
      $display("%0t results missing: expected %0d actual 0", $time, sb.expected_stats.size());
    end
    if (sb.errors == 0) begin
      $display("[column_token_type_profiler] OK");
    end else begin
      $display("[column_token_type_profiler] ERROR");
    end
    $finish;
  end

endmodule
